[rtl/bspg_pkg.sv]
// Shared types, widths and codes for the brush stroke pixel generator.
// Used by the channel interfaces and by every module of the block.
// No dependencies.
`timescale 1ns / 1ps

package bspg_pkg;

	// Field widths and sizing constants
	localparam int COORD_BITS = 12;
	localparam int MAX_BRUSH  = 20;
	localparam int CMD_W      = 2;
	localparam int SIZE_W     = 5;
	localparam int COLOR_W    = 24;
	localparam int DIM_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int MODE_W     = 2;

	// Disk scan geometry follows from the largest brush.
	localparam int RAD_MAX = (MAX_BRUSH + 1) / 2;
	localparam int RAD_W   = $clog2(RAD_MAX + 1);
	localparam int SPAN_W  = RAD_W + 1;
	localparam int OFF_W   = SPAN_W + 1;
	localparam int SQ_W    = 2 * OFF_W;

	// Line walker error term and the extended width for clipping compares.
	localparam int ERR_W = COORD_BITS + 2;
	localparam int EXT_W = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic [DIM_W-1:0]     DIM_RESET        = 13'd800;

	// Stroke work modes
	localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LINE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DISK  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_POINT = 2'd3;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} bspg_cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]      cmd;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [SIZE_W-1:0]     brush_size;
		logic [COLOR_W-1:0]    paint_color;
	} bspg_cmd_t;

	typedef struct packed {
		logic                  write_valid;
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [COLOR_W-1:0]    pixel_color;
		logic                  pending;
		logic                  rejected;
	} bspg_res_t;

	// Walker status toward the top level
	typedef struct packed {
		logic idle;
		logic res_valid;
	} bspg_wstat_t;

endpackage

[rtl/bspg_if.sv]
// Valid/ready channel interfaces for pen items and pixel result items.
// Depends on bspg_pkg for field widths.
`timescale 1ns / 1ps

interface bspg_in_if import bspg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [SIZE_W-1:0]     brush_size;
	logic [COLOR_W-1:0]    paint_color;

	modport source (output valid, cmd, pos_x, pos_y, brush_size, paint_color, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, brush_size, paint_color, output ready);
endinterface

interface bspg_out_if import bspg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  write_valid;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  pending;
	logic                  rejected;

	modport source (output valid, write_valid, pixel_x, pixel_y, pixel_color, pending,
		rejected, input ready);
	modport sink (input valid, write_valid, pixel_x, pixel_y, pixel_color, pending,
		rejected, output ready);
endinterface

[rtl/bspg_disk_check.sv]
// Shared candidate test: disk membership of an offset and clipping to the canvas.
// Depends on bspg_pkg.
`timescale 1ns / 1ps

module bspg_disk_check import bspg_pkg::*; (
	input  bspg_cfg_t                  cfg,
	input  logic [COORD_BITS-1:0]      base_x,
	input  logic [COORD_BITS-1:0]      base_y,
	input  logic signed [OFF_W-1:0]    off_x,
	input  logic signed [OFF_W-1:0]    off_y,
	input  logic [RAD_W-1:0]           radius,
	output logic                       kept
);

	logic signed [EXT_W-1:0] cand_x;
	logic signed [EXT_W-1:0] cand_y;
	logic                    in_x;
	logic                    in_y;
	logic signed [SQ_W-1:0]  sq_x;
	logic signed [SQ_W-1:0]  sq_y;
	logic [SQ_W:0]           sum_sq;
	logic [2*RAD_W-1:0]      rad_sq;
	logic                    in_disk;

	// Candidate coordinates, sign extended so that negatives stay visible.
	assign cand_x = $signed({{(EXT_W-COORD_BITS){1'b0}}, base_x})
		+ $signed({{(EXT_W-OFF_W){off_x[OFF_W-1]}}, off_x});
	assign cand_y = $signed({{(EXT_W-COORD_BITS){1'b0}}, base_y})
		+ $signed({{(EXT_W-OFF_W){off_y[OFF_W-1]}}, off_y});

	// Inside the image and inside the coordinate range.
	assign in_x = !cand_x[EXT_W-1]
		&& ($unsigned(cand_x) < {{(EXT_W-DIM_W){1'b0}}, cfg.image_width})
		&& (cand_x[EXT_W-2:COORD_BITS] == '0);
	assign in_y = !cand_y[EXT_W-1]
		&& ($unsigned(cand_y) < {{(EXT_W-DIM_W){1'b0}}, cfg.image_height})
		&& (cand_y[EXT_W-2:COORD_BITS] == '0);

	// Disk test on the small offsets.
	assign sq_x    = off_x * off_x;
	assign sq_y    = off_y * off_y;
	assign sum_sq  = {1'b0, $unsigned(sq_x)} + {1'b0, $unsigned(sq_y)};
	assign rad_sq  = radius * radius;
	assign in_disk = sum_sq <= {{(SQ_W+1-2*RAD_W){1'b0}}, rad_sq};

	assign kept = in_disk && in_x && in_y;

endmodule

[rtl/bspg_walker.sv]
// Stroke state and the sequencer that walks the Bresenham line and disk scan,
// one candidate or one line step per cycle while it seeks. Depends on bspg_pkg, bspg_disk_check.
`timescale 1ns / 1ps

module bspg_walker import bspg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bspg_cfg_t   cfg,
	input  logic        go,
	input  bspg_cmd_t   cmd,
	input  logic        res_take,
	output bspg_wstat_t stat,
	output bspg_res_t   res
);

	localparam logic [1:0] W_IDLE = 2'd0;
	localparam logic [1:0] W_SEEK = 2'd1;
	localparam logic [1:0] W_DONE = 2'd2;

	// Control state
	logic [1:0]        fsm_q, fsm_d;
	logic [MODE_W-1:0] mode_q, mode_d;
	logic              last_valid_q, last_valid_d;

	// Stroke payload state
	logic [COORD_BITS-1:0]   last_x_q, last_x_d, last_y_q, last_y_d;
	logic [COORD_BITS-1:0]   line_x_q, line_x_d, line_y_q, line_y_d;
	logic [COORD_BITS-1:0]   end_x_q, end_x_d, end_y_q, end_y_d;
	logic [COORD_BITS-1:0]   dx_q, dx_d, dy_q, dy_d;
	logic signed [ERR_W-1:0] err_q, err_d;
	logic [1:0]              signs_q, signs_d;
	logic [RAD_W-1:0]        rad_q, rad_d;
	logic [SPAN_W-1:0]       scan_dx_q, scan_dx_d, scan_dy_q, scan_dy_d;
	logic [COLOR_W-1:0]      color_q, color_d;
	logic                    skip_q, skip_d;
	bspg_res_t               res_q, res_d;

	// Shared checker operands
	logic                    chk_kept;
	logic [COORD_BITS-1:0]   chk_x, chk_y;
	logic signed [OFF_W-1:0] chk_ox, chk_oy;
	logic [RAD_W-1:0]        chk_r;

	// Scan and line step helpers
	logic signed [OFF_W-1:0] ox, oy;
	logic [SPAN_W-1:0]       span;
	logic                    scan_in;
	logic [SPAN_W-1:0]       dy_inc;
	logic signed [ERR_W:0]   e2, neg_dy, dx_ext, dy_ext, err_ext, err_next;
	logic                    step_x, step_y;
	logic [COORD_BITS-1:0]   x_next, y_next;
	logic [SIZE_W-1:0]       size_sat;
	logic [SIZE_W:0]         size_inc;
	logic [COORD_BITS-1:0]   cur_x, cur_y;

	assign ox = $signed({1'b0, scan_dx_q}) - $signed({{(OFF_W-RAD_W){1'b0}}, rad_q});
	assign oy = $signed({1'b0, scan_dy_q}) - $signed({{(OFF_W-RAD_W){1'b0}}, rad_q});

	// Coordinates of the candidate the walker rests on.
	assign cur_x = line_x_q + {{(COORD_BITS-OFF_W){ox[OFF_W-1]}}, ox};
	assign cur_y = line_y_q + {{(COORD_BITS-OFF_W){oy[OFF_W-1]}}, oy};

	// While idle the checker clips the incoming point; otherwise it tests the scan.
	assign chk_x  = (fsm_q == W_IDLE) ? cmd.pos_x : line_x_q;
	assign chk_y  = (fsm_q == W_IDLE) ? cmd.pos_y : line_y_q;
	assign chk_ox = (fsm_q == W_IDLE) ? '0 : ox;
	assign chk_oy = (fsm_q == W_IDLE) ? '0 : oy;
	assign chk_r  = (fsm_q == W_IDLE) ? '0 : rad_q;

	bspg_disk_check u_check (
		.cfg    (cfg),
		.base_x (chk_x),
		.base_y (chk_y),
		.off_x  (chk_ox),
		.off_y  (chk_oy),
		.radius (chk_r),
		.kept   (chk_kept)
	);

	// Scan bounds
	assign span    = {rad_q, 1'b0};
	assign scan_in = (scan_dx_q < span) && (scan_dy_q < span);
	assign dy_inc  = scan_dy_q + 1'b1;

	// Bresenham step
	assign dx_ext   = $signed({{(ERR_W+1-COORD_BITS){1'b0}}, dx_q});
	assign dy_ext   = $signed({{(ERR_W+1-COORD_BITS){1'b0}}, dy_q});
	assign err_ext  = {err_q[ERR_W-1], err_q};
	assign e2       = {err_q, 1'b0};
	assign neg_dy   = -dy_ext;
	assign step_x   = e2 > neg_dy;
	assign step_y   = e2 < dx_ext;
	assign err_next = err_ext - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
	assign x_next   = step_x ? (signs_q[0] ? line_x_q - 1'b1 : line_x_q + 1'b1) : line_x_q;
	assign y_next   = step_y ? (signs_q[1] ? line_y_q - 1'b1 : line_y_q + 1'b1) : line_y_q;

	// Brush size saturation and radius
	assign size_sat = (cmd.brush_size > SIZE_W'(MAX_BRUSH)) ? SIZE_W'(MAX_BRUSH)
		: cmd.brush_size;
	assign size_inc = {1'b0, size_sat} + 1'b1;

	// Sequencer next state
	always_comb begin
		fsm_d        = fsm_q;
		mode_d       = mode_q;
		last_valid_d = last_valid_q;
		last_x_d     = last_x_q;
		last_y_d     = last_y_q;
		line_x_d     = line_x_q;
		line_y_d     = line_y_q;
		end_x_d      = end_x_q;
		end_y_d      = end_y_q;
		dx_d         = dx_q;
		dy_d         = dy_q;
		err_d        = err_q;
		signs_d      = signs_q;
		rad_d        = rad_q;
		scan_dx_d    = scan_dx_q;
		scan_dy_d    = scan_dy_q;
		color_d      = color_q;
		skip_d       = skip_q;
		res_d        = res_q;
		case (fsm_q)
			W_IDLE: begin
				if (go) begin
					res_d = '0;
					fsm_d = W_DONE;
					case (cmd.cmd)
						CMD_SAMPLE: begin
							if (mode_q != MODE_IDLE) begin
								res_d.rejected = 1'b1;
							end else begin
								rad_d     = size_inc[RAD_W:1];
								scan_dx_d = '0;
								scan_dy_d = '0;
								line_x_d  = cmd.pos_x;
								line_y_d  = cmd.pos_y;
								color_d   = cmd.paint_color;
								skip_d    = 1'b0;
								if (last_valid_q) begin
									end_x_d   = last_x_q;
									end_y_d   = last_y_q;
									dx_d      = (last_x_q > cmd.pos_x) ? last_x_q - cmd.pos_x
										: cmd.pos_x - last_x_q;
									dy_d      = (last_y_q > cmd.pos_y) ? last_y_q - cmd.pos_y
										: cmd.pos_y - last_y_q;
									signs_d   = {!(cmd.pos_y < last_y_q), !(cmd.pos_x < last_x_q)};
									err_d     = $signed({{(ERR_W-COORD_BITS){1'b0}}, dx_d})
										- $signed({{(ERR_W-COORD_BITS){1'b0}}, dy_d});
									if (cmd.pos_x == last_x_q && cmd.pos_y == last_y_q) begin
										mode_d = MODE_IDLE;
									end else begin
										mode_d = MODE_LINE;
										fsm_d  = W_SEEK;
									end
								end else if (size_sat == SIZE_W'(1)) begin
									mode_d = chk_kept ? MODE_POINT : MODE_IDLE;
								end else begin
									mode_d = MODE_DISK;
									fsm_d  = W_SEEK;
								end
								last_valid_d = 1'b1;
								last_x_d     = cmd.pos_x;
								last_y_d     = cmd.pos_y;
							end
						end
						CMD_RELEASE: begin
							last_valid_d = 1'b0;
						end
						CMD_ADVANCE: begin
							if (mode_q == MODE_POINT) begin
								res_d.write_valid = 1'b1;
								res_d.pixel_x     = line_x_q;
								res_d.pixel_y     = line_y_q;
								res_d.pixel_color = color_q;
								mode_d            = MODE_IDLE;
							end else if (mode_q != MODE_IDLE) begin
								res_d.write_valid = 1'b1;
								res_d.pixel_x     = cur_x;
								res_d.pixel_y     = cur_y;
								res_d.pixel_color = color_q;
								skip_d            = 1'b1;
								fsm_d             = W_SEEK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			W_SEEK: begin
				if (mode_q != MODE_LINE && mode_q != MODE_DISK) begin
					fsm_d = W_DONE;
				end else if (scan_in) begin
					if (!skip_q && chk_kept) begin
						fsm_d = W_DONE;
					end else begin
						skip_d = 1'b0;
						if (dy_inc >= span) begin
							scan_dy_d = '0;
							scan_dx_d = scan_dx_q + 1'b1;
						end else begin
							scan_dy_d = dy_inc;
						end
					end
				end else if (mode_q == MODE_DISK) begin
					mode_d = MODE_IDLE;
					fsm_d  = W_DONE;
				end else begin
					// Scan of this stamp is over: step the line by one pixel.
					line_x_d = x_next;
					line_y_d = y_next;
					err_d    = err_next[ERR_W-1:0];
					if (x_next == end_x_q && y_next == end_y_q) begin
						mode_d = MODE_IDLE;
						fsm_d  = W_DONE;
					end else begin
						scan_dx_d = '0;
						scan_dy_d = '0;
					end
				end
			end
			W_DONE: begin
				if (res_take) begin
					fsm_d = W_IDLE;
				end
			end
			default: begin
				fsm_d = W_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q        <= W_IDLE;
			mode_q       <= MODE_IDLE;
			last_valid_q <= 1'b0;
		end else begin
			fsm_q        <= fsm_d;
			mode_q       <= mode_d;
			last_valid_q <= last_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		last_x_q  <= last_x_d;
		last_y_q  <= last_y_d;
		line_x_q  <= line_x_d;
		line_y_q  <= line_y_d;
		end_x_q   <= end_x_d;
		end_y_q   <= end_y_d;
		dx_q      <= dx_d;
		dy_q      <= dy_d;
		err_q     <= err_d;
		signs_q   <= signs_d;
		rad_q     <= rad_d;
		scan_dx_q <= scan_dx_d;
		scan_dy_q <= scan_dy_d;
		color_q   <= color_d;
		skip_q    <= skip_d;
		res_q     <= res_d;
	end

	// Pending reflects the mode left behind once the walk has settled.
	always_comb begin
		res         = res_q;
		res.pending = (mode_q != MODE_IDLE);
	end

	assign stat.idle      = (fsm_q == W_IDLE);
	assign stat.res_valid = (fsm_q == W_DONE);

endmodule

[rtl/brush_stroke_pixel_generator_core.sv]
// Top level of the brush stroke pixel generator: configuration registers,
// input handshake and result output register. Depends on bspg_pkg, bspg_if, bspg_walker.
//
// Channel | Dir | Handshake     | Carries
// pen     | in  | valid / ready | cmd, pos_x, pos_y, brush_size, paint_color
// pix     | out | valid / ready | write_valid, pixel_x, pixel_y, pixel_color, pending, rejected
// cfg     | in  | cfg_we        | cfg_index, cfg_wdata (image width and height)
//
// Each item yields exactly one result item. Releases, rejected samples and point items need
// no walk. An item that walks the stroke passes each disk candidate it skips (an advance
// first passes the pixel it writes) and each line step, then lands on the next pixel or
// closes the disk scan; a walk that stops at the line's end needs no landing.
// Reset is asynchronous and active low; it clears the pen state and sets both
// dimensions to 800. A result waits in the output register while the next item is taken;
// the walker holds its result while that register is still full and the receiver is not ready.
`timescale 1ns / 1ps

module brush_stroke_pixel_generator_core import bspg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_wdata,
	bspg_in_if.sink              pen,
	bspg_out_if.source           pix
);

	bspg_cfg_t   cfg_q;
	bspg_cmd_t   cmd;
	bspg_wstat_t wstat;
	bspg_res_t   wres;
	bspg_res_t   out_q;
	logic        out_valid_q;
	logic        go;
	logic        load;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= DIM_RESET;
			cfg_q.image_height <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata;
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Input item handshake
	assign pen.ready       = wstat.idle;
	assign go              = pen.valid && wstat.idle;
	assign cmd.cmd         = pen.cmd;
	assign cmd.pos_x       = pen.pos_x;
	assign cmd.pos_y       = pen.pos_y;
	assign cmd.brush_size  = pen.brush_size;
	assign cmd.paint_color = pen.paint_color;

	bspg_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.go       (go),
		.cmd      (cmd),
		.res_take (load),
		.stat     (wstat),
		.res      (wres)
	);

	// Output register
	assign load = wstat.res_valid && (!out_valid_q || pix.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= wres;
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.write_valid = out_q.write_valid;
	assign pix.pixel_x     = out_q.pixel_x;
	assign pix.pixel_y     = out_q.pixel_y;
	assign pix.pixel_color = out_q.pixel_color;
	assign pix.pending     = out_q.pending;
	assign pix.rejected    = out_q.rejected;

endmodule

[dv/brush_stroke_pixel_generator_core_tb.sv]
// Self-checking testbench for brush_stroke_pixel_generator_core: drives pen items,
// predicts every pixel result from its own stroke walker and compares it field by field.
// Depends on bspg_pkg, the channel interfaces in bspg_if and the block's RTL.
`timescale 1ns / 1ps

module brush_stroke_pixel_generator_core_tb;
	import bspg_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_wdata;

	bspg_in_if  pen_ch ();
	bspg_out_if pix_ch ();

	brush_stroke_pixel_generator_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pen      (pen_ch),
		.pix      (pix_ch)
	);

	// Predicted state of the stroke walker and canvas.
	logic [DIM_W-1:0]   canvas_w = DIM_RESET;
	logic [DIM_W-1:0]   canvas_h = DIM_RESET;
	bit                 have_last = 1'b0;
	int                 prev_x = 0, prev_y = 0;
	int                 cur_x = 0, cur_y = 0, goal_x = 0, goal_y = 0;
	int                 run_x = 0, run_y = 0, err_acc = 0;
	bit                 neg_x = 1'b0, neg_y = 1'b0;
	int                 rad = 0, scan_i = 0, scan_j = 0;
	logic [COLOR_W-1:0] stroke_color = '0;
	logic [MODE_W-1:0]  stroke_mode = MODE_IDLE;

	bspg_res_t expected_pixels[$];
	bspg_res_t seen_want;

	// Run bookkeeping.
	int mismatch_count = 0;
	int results_checked = 0;
	int useful_items = 0;
	int write_count = 0;
	int reject_count = 0;
	int canvas_count = 1;
	int quiet_cycles = 0;
	int sender_calm = 0;
	bit traffic_gaps = 1'b1;
	bit hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Canvas clipping plus the coordinate range of the outputs.
	function automatic bit on_canvas(input int x, input int y);
		return x >= 0 && y >= 0 && x < int'(canvas_w) && y < int'(canvas_h)
			&& x <= COORD_MAX && y <= COORD_MAX;
	endfunction

	function automatic bit candidate_kept();
		int ox, oy;
		ox = scan_i - rad;
		oy = scan_j - rad;
		if (ox * ox + oy * oy > rad * rad)
			return 1'b0;
		return on_canvas(cur_x + ox, cur_y + oy);
	endfunction

	// Move the walker onto the next pixel to emit, stepping the line when a stamp is done.
	function automatic void walk_stroke(input bit skip_first);
		int e2;
		bit skip, searching;
		skip = skip_first;
		searching = stroke_mode == MODE_LINE || stroke_mode == MODE_DISK;
		while (searching) begin
			if (scan_i < 2 * rad && scan_j < 2 * rad) begin
				if (!skip && candidate_kept()) begin
					searching = 1'b0;
				end else begin
					skip = 1'b0;
					scan_j++;
					if (scan_j >= 2 * rad) begin
						scan_j = 0;
						scan_i++;
					end
				end
			end else if (stroke_mode == MODE_DISK) begin
				stroke_mode = MODE_IDLE;
				searching = 1'b0;
			end else begin
				e2 = 2 * err_acc;
				if (e2 > -run_y) begin
					cur_x += neg_x ? -1 : 1;
					err_acc -= run_y;
				end
				if (e2 < run_x) begin
					cur_y += neg_y ? -1 : 1;
					err_acc += run_x;
				end
				if (cur_x == goal_x && cur_y == goal_y) begin
					stroke_mode = MODE_IDLE;
					searching = 1'b0;
				end else begin
					scan_i = 0;
					scan_j = 0;
				end
			end
		end
	endfunction

	// A sample accepted while idle starts a point, a disk, a line toward the last position, or nothing.
	function automatic void start_stroke(input int px, input int py, input int size,
			input logic [COLOR_W-1:0] color);
		if (size > MAX_BRUSH)
			size = MAX_BRUSH;
		rad = (size + 1) >> 1;
		scan_i = 0;
		scan_j = 0;
		cur_x = px;
		cur_y = py;
		stroke_color = color;
		if (have_last) begin
			goal_x = prev_x;
			goal_y = prev_y;
			run_x = goal_x > px ? goal_x - px : px - goal_x;
			run_y = goal_y > py ? goal_y - py : py - goal_y;
			neg_x = !(px < goal_x);
			neg_y = !(py < goal_y);
			err_acc = run_x - run_y;
			if (px == goal_x && py == goal_y) begin
				stroke_mode = MODE_IDLE;
			end else begin
				stroke_mode = MODE_LINE;
				walk_stroke(1'b0);
			end
		end else if (size == 1) begin
			stroke_mode = on_canvas(px, py) ? MODE_POINT : MODE_IDLE;
		end else begin
			stroke_mode = MODE_DISK;
			walk_stroke(1'b0);
		end
		have_last = 1'b1;
		prev_x = px;
		prev_y = py;
	endfunction

	// Expected result item for one accepted pen item; updates the predicted state.
	function automatic bspg_res_t stroke_result(input bspg_cmd_t item);
		bspg_res_t res;
		int wx, wy;
		res = '0;
		case (item.cmd)
			CMD_SAMPLE: begin
				if (stroke_mode != MODE_IDLE)
					res.rejected = 1'b1;
				else
					start_stroke(item.pos_x, item.pos_y, item.brush_size, item.paint_color);
			end
			CMD_RELEASE: have_last = 1'b0;
			CMD_ADVANCE: begin
				if (stroke_mode != MODE_IDLE) begin
					res.write_valid = 1'b1;
					res.pixel_color = stroke_color;
					if (stroke_mode == MODE_POINT) begin
						wx = cur_x;
						wy = cur_y;
						stroke_mode = MODE_IDLE;
					end else begin
						wx = cur_x + scan_i - rad;
						wy = cur_y + scan_j - rad;
						walk_stroke(1'b1);
					end
					res.pixel_x = wx[COORD_BITS-1:0];
					res.pixel_y = wy[COORD_BITS-1:0];
				end
			end
			default: ;
		endcase
		res.pending = stroke_mode != MODE_IDLE;
		return res;
	endfunction

	function automatic int clamp_coord(input int v);
		return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
	endfunction

	// Coordinate mostly within the canvas, sometimes zero or near its far side, with the odd extreme or stray value.
	function automatic int pick_coord(input int extent);
		int roll, top;
		roll = $urandom_range(0, 9);
		top = extent > COORD_MAX + 1 ? COORD_MAX : extent - 1;
		case (roll)
			0: return 0;
			1: return COORD_MAX;
			2: return clamp_coord(top + $urandom_range(0, 6) - 3);
			3: return $urandom_range(0, COORD_MAX);
			default: return $urandom_range(0, top);
		endcase
	endfunction

	function automatic int nudge(input int base, input int reach);
		return clamp_coord(base + $urandom_range(0, 2 * reach) - reach);
	endfunction

	// Item of the given command with random content in every field.
	function automatic bspg_cmd_t noise_item(input logic [CMD_W-1:0] cmd);
		logic [63:0] bits;
		bspg_cmd_t item;
		bits = {$urandom, $urandom};
		item = bits[$bits(bspg_cmd_t)-1:0];
		item.cmd = cmd;
		return item;
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch at result %0d: %s", $time, results_checked, what);
	endtask

	// Offer one item, wait for it to be taken and queue its expected result.
	task automatic send_pen(input bspg_cmd_t item);
		bspg_res_t want;
		if (sender_calm > 0) begin
			sender_calm--;
		end else if (traffic_gaps && $urandom_range(0, 19) == 0) begin
			sender_calm = $urandom_range(10, 40);
		end else if (traffic_gaps && $urandom_range(0, 3) == 0) begin
			pen_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pen_ch.valid       <= 1'b1;
		pen_ch.cmd         <= item.cmd;
		pen_ch.pos_x       <= item.pos_x;
		pen_ch.pos_y       <= item.pos_y;
		pen_ch.brush_size  <= item.brush_size;
		pen_ch.paint_color <= item.paint_color;
		do @(posedge clk); while (pen_ch.ready !== 1'b1);
		want = stroke_result(item);
		expected_pixels.push_back(want);
		if (want.write_valid)
			write_count++;
		if (want.rejected)
			reject_count++;
		if (!(want.rejected || item.cmd == CMD_UNUSED
				|| (item.cmd == CMD_ADVANCE && !want.write_valid)))
			useful_items++;
	endtask

	task automatic draw_sample(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input logic [SIZE_W-1:0] size, input logic [COLOR_W-1:0] color);
		bspg_cmd_t item;
		item.cmd = CMD_SAMPLE;
		item.pos_x = x;
		item.pos_y = y;
		item.brush_size = size;
		item.paint_color = color;
		send_pen(item);
	endtask

	task automatic finish_stroke();
		while (stroke_mode != MODE_IDLE)
			send_pen(noise_item(CMD_ADVANCE));
	endtask

	// Stop offering items until every expected result has come out.
	task automatic wait_drained();
		pen_ch.valid <= 1'b0;
		wait (expected_pixels.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[DIM_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			canvas_w = value[DIM_W-1:0];
		else
			canvas_h = value[DIM_W-1:0];
		@(posedge clk);
	endtask

	// The canvas only changes with no stroke in progress and nothing in flight.
	task automatic set_canvas(input int w, input int h);
		finish_stroke();
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		canvas_count++;
	endtask

	// Idle advances, the unused command, points, rejected samples and empty strokes.
	task automatic test_idle_corner_cases();
		send_pen(noise_item(CMD_ADVANCE));
		send_pen(noise_item(CMD_UNUSED));
		draw_sample(0, 0, 1, 24'hFFFFFF);
		draw_sample(5, 5, 1, 24'h000000);
		send_pen(noise_item(CMD_ADVANCE));
		send_pen(noise_item(CMD_ADVANCE));
		draw_sample(0, 0, 1, 24'h123456);
		send_pen(noise_item(CMD_RELEASE));
		draw_sample(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 1, 24'hABCDEF);
		send_pen(noise_item(CMD_RELEASE));
		draw_sample(3, 2, 0, 24'h00FF00);
		draw_sample(9, 7, 0, 24'h0000FF);
		send_pen(noise_item(CMD_ADVANCE));
	endtask

	// Saturated and largest brushes clipped at the corner, release mid-stroke, long lines.
	task automatic test_brush_extremes();
		send_pen(noise_item(CMD_RELEASE));
		draw_sample(0, 0, 31, 24'hFF0000);
		draw_sample(5, 5, 3, 24'h00FF00);
		finish_stroke();
		draw_sample(2, 1, 20, 24'h00FFFF);
		send_pen(noise_item(CMD_RELEASE));
		finish_stroke();
		draw_sample(0, 0, 2, 24'hFFFFFF);
		finish_stroke();
		// Full-range line with an empty stamp, then one whose stamps all fall off the canvas.
		draw_sample(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 0, 24'h808080);
		draw_sample(COORD_BITS'(COORD_MAX), 0, 1, 24'h7F7F7F);
		send_pen(noise_item(CMD_ADVANCE));
	endtask

	// Largest and smallest canvas sides, with strokes at their corners.
	task automatic test_canvas_extremes();
		set_canvas(4096, 4096);
		send_pen(noise_item(CMD_RELEASE));
		draw_sample(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 5, 24'hC0FFEE);
		finish_stroke();
		draw_sample(COORD_BITS'(COORD_MAX - 7), COORD_BITS'(COORD_MAX), 1, 24'h0F0F0F);
		finish_stroke();
		set_canvas(1, 1);
		send_pen(noise_item(CMD_RELEASE));
		draw_sample(0, 0, 3, 24'hF0F0F0);
		finish_stroke();
		draw_sample(1, 0, 1, 24'h55AA55);
		finish_stroke();
		set_canvas(4096, 1);
		send_pen(noise_item(CMD_RELEASE));
		draw_sample(COORD_BITS'(COORD_MAX), 0, 7, 24'hAA55AA);
		finish_stroke();
		set_canvas(1, 4096);
		send_pen(noise_item(CMD_RELEASE));
		draw_sample(0, COORD_BITS'(COORD_MAX), 4, 24'h3C3C3C);
		finish_stroke();
	endtask

	// Random strokes walked out to the end, with stray items mixed in.
	task automatic test_random_strokes(input int target);
		int stop_at, roll, size, reach, nx, ny;
		stop_at = useful_items + target;
		while (useful_items < stop_at) begin
			roll = $urandom_range(0, 99);
			if (roll < 15)
				send_pen(noise_item(CMD_RELEASE));
			else if (roll < 19)
				send_pen(noise_item(CMD_ADVANCE));
			else if (roll < 22)
				send_pen(noise_item(CMD_UNUSED));
			// Mostly small brushes; big ones only make short lines.
			roll = $urandom_range(0, 99);
			if (roll < 45)
				size = $urandom_range(0, 2);
			else if (roll < 94)
				size = $urandom_range(3, 8);
			else
				size = $urandom_range(9, 31);
			reach = size == 0 ? 400 : (size <= 2 ? 24 : (size <= 8 ? 4 : 1));
			if (!have_last || $urandom_range(0, 7) == 0) begin
				if (have_last && size != 0)
					send_pen(noise_item(CMD_RELEASE));
				nx = pick_coord(int'(canvas_w));
				ny = pick_coord(int'(canvas_h));
			end else begin
				nx = nudge(prev_x, reach);
				ny = nudge(prev_y, reach);
			end
			draw_sample(nx[COORD_BITS-1:0], ny[COORD_BITS-1:0], size[SIZE_W-1:0],
				COLOR_W'($urandom));
			while (stroke_mode != MODE_IDLE) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					send_pen(noise_item(CMD_SAMPLE));
				else if (roll < 5)
					send_pen(noise_item(CMD_RELEASE));
				else if (roll < 6)
					send_pen(noise_item(CMD_UNUSED));
				else
					send_pen(noise_item(CMD_ADVANCE));
			end
		end
	endtask

	// The receiver holds off for a long stretch while items keep being offered.
	task automatic test_output_stall();
		hold_request = 1'b1;
		test_random_strokes(80);
	endtask

	// The sender stops mid-stream until every result is out, then carries on.
	task automatic test_sender_pause();
		test_random_strokes(60);
		wait_drained();
		test_random_strokes(60);
	endtask

	// Result receiver: random stall bursts, calm stretches and the long hold-off.
	initial begin : result_sink
		int stall_left, calm_left, hold_left, roll;
		stall_left = 0;
		calm_left = 0;
		hold_left = 0;
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pix_ch.ready <= 1'b0;
			end else if (calm_left > 0 || !traffic_gaps) begin
				if (calm_left > 0)
					calm_left--;
				pix_ch.ready <= 1'b1;
			end else begin
				roll = $urandom_range(0, 15);
				if (roll == 0) begin
					calm_left = $urandom_range(20, 80);
					pix_ch.ready <= 1'b1;
				end else if (roll < 5) begin
					stall_left = $urandom_range(1, 6) - 1;
					pix_ch.ready <= 1'b0;
				end else begin
					pix_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Compare each accepted result item with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
			results_checked++;
			if (expected_pixels.size() == 0) begin
				note_mismatch("result item with nothing expected");
			end else begin
				seen_want = expected_pixels.pop_front();
				if (pix_ch.write_valid !== seen_want.write_valid)
					note_mismatch($sformatf("write_valid got %0b want %0b",
						pix_ch.write_valid, seen_want.write_valid));
				if (pix_ch.pixel_x !== seen_want.pixel_x)
					note_mismatch($sformatf("pixel_x got %0d want %0d",
						pix_ch.pixel_x, seen_want.pixel_x));
				if (pix_ch.pixel_y !== seen_want.pixel_y)
					note_mismatch($sformatf("pixel_y got %0d want %0d",
						pix_ch.pixel_y, seen_want.pixel_y));
				if (pix_ch.pixel_color !== seen_want.pixel_color)
					note_mismatch($sformatf("pixel_color got %06h want %06h",
						pix_ch.pixel_color, seen_want.pixel_color));
				if (pix_ch.pending !== seen_want.pending)
					note_mismatch($sformatf("pending got %0b want %0b",
						pix_ch.pending, seen_want.pending));
				if (pix_ch.rejected !== seen_want.rejected)
					note_mismatch($sformatf("rejected got %0b want %0b",
						pix_ch.rejected, seen_want.rejected));
			end
		end
	end

	// Watchdog: too many cycles in a row with no item moving on either channel.
	always @(posedge clk) begin
		if ((pen_ch.valid === 1'b1 && pen_ch.ready === 1'b1)
				|| (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_pixels.size());
			$display("FAIL brush_stroke_pixel_generator_core");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_IMAGE_WIDTH;
		cfg_wdata          <= '0;
		pen_ch.valid       <= 1'b0;
		pen_ch.cmd         <= CMD_SAMPLE;
		pen_ch.pos_x       <= '0;
		pen_ch.pos_y       <= '0;
		pen_ch.brush_size  <= '0;
		pen_ch.paint_color <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_corner_cases();
		test_brush_extremes();
		test_canvas_extremes();
		set_canvas(800, 800);
		test_random_strokes(250);
		set_canvas(37, 23);
		test_random_strokes(150);
		set_canvas(4096, 4096);
		test_output_stall();
		set_canvas(300, 200);
		test_sender_pause();
		// Last stretch runs with both sides always willing.
		traffic_gaps = 1'b0;
		set_canvas(800, 600);
		test_random_strokes(150);
		wait_drained();

		$display("Checked %0d result items from %0d working pen items: %0d pixel writes,",
			results_checked, useful_items, write_count);
		$display("%0d rejected samples, %0d canvas sizes, %0d mismatches.",
			reject_count, canvas_count, mismatch_count);
		if (mismatch_count == 0)
			$display("PASS brush_stroke_pixel_generator_core");
		else
			$display("FAIL brush_stroke_pixel_generator_core");
		$finish;
	end

endmodule
